// ----- design/kwsc_pkg.sv -----
// Shared constants, codes and types of the keyword substitution cipher.
`default_nettype none
package kwsc_pkg;

   localparam int unsigned ALPHA_SIZE = 26;
   localparam int unsigned IDX_W      = $clog2(ALPHA_SIZE);
   localparam int unsigned FILL_W     = $clog2(ALPHA_SIZE + 1);

   localparam logic [7:0] CHAR_A_UP   = 8'h41;
   localparam logic [7:0] CHAR_Z_UP   = 8'h5a;
   localparam logic [7:0] CHAR_A_LO   = 8'h61;
   localparam logic [7:0] CHAR_Z_LO   = 8'h7a;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CASE_OFFSET = 8'd32;

   localparam logic [2:0] OP_CLEAR   = 3'd0;
   localparam logic [2:0] OP_KEY     = 3'd1;
   localparam logic [2:0] OP_FINISH  = 3'd2;
   localparam logic [2:0] OP_ENCRYPT = 3'd3;
   localparam logic [2:0] OP_DECRYPT = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_REJECTED  = 2'd1;
   localparam logic [1:0] ST_NOT_READY = 2'd2;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] fwd_addr;
      logic [IDX_W-1:0] fwd_data;
      logic [IDX_W-1:0] inv_addr;
      logic [IDX_W-1:0] inv_data;
   } kwsc_wr_type;

endpackage
`default_nettype wire

// ----- design/kwsc_tables.sv -----
// Forward and inverse substitution table memories, one write and one registered read each.
`default_nettype none
module kwsc_tables
   import kwsc_pkg::*;
(
   input  wire logic             clock,
   input  wire kwsc_wr_type      wr,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_addr,
   output logic      [IDX_W-1:0] fwd_q_ff,
   output logic      [IDX_W-1:0] inv_q_ff
);

   logic [IDX_W-1:0] fwd_mem [ALPHA_SIZE];
   logic [IDX_W-1:0] inv_mem [ALPHA_SIZE];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         fwd_mem[wr.fwd_addr] <= wr.fwd_data;
         inv_mem[wr.inv_addr] <= wr.inv_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_q_ff <= fwd_mem[rd_addr];
         inv_q_ff <= inv_mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- design/keyword_substitution_cipher.sv -----
// Top level of the keyword substitution cipher: control, key state and result register.
`default_nettype none
// Clear, key-character, unknown and non-letter text beats answer from the idle state, and so
// do text beats and finish key while the table is not in the state that needs the memory.
// A letter under encrypt or decrypt with the table ready passes through the read state,
// which loads the registered table read into the result once the result register is
// free. Finish key on an unready table walks the 26 letters one per cycle through the
// single table write port, then loads the result. One beat is in flight at a time, and
// a new beat is taken only once the result register is empty or being drained. The tables
// hold no reset value; they are read only after finish key has written every entry.
module keyword_substitution_cipher
   import kwsc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [2:0] req_operation,
   input  wire logic [7:0] req_char_in,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic      [7:0] rsp_char_out,
   output logic      [1:0] rsp_status
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_FILL = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [ALPHA_SIZE-1:0]  mask_ff, mask_in;
   logic [FILL_W-1:0]      fill_count_ff, fill_count_in;
   logic                   ready_ff, ready_in;
   logic [IDX_W-1:0]       walk_ff, walk_in;
   logic                   dec_ff, dec_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_char_ff, rsp_char_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;

   kwsc_wr_type            wr;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic [IDX_W-1:0]       fwd_q_ff, inv_q_ff;

   logic                   out_free;
   logic                   req_accept;
   logic [7:0]             folded;
   logic                   is_letter;
   logic [IDX_W-1:0]       letter_idx;
   logic [IDX_W-1:0]       fill_idx;
   logic [IDX_W-1:0]       mapped;

   kwsc_tables u_tables (
      .clock    (clock),
      .wr       (wr),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .fwd_q_ff (fwd_q_ff),
      .inv_q_ff (inv_q_ff)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == S_IDLE) && out_free);
   assign req_accept = req_valid && !req_stall;
   assign fill_idx   = fill_count_ff[IDX_W-1:0];
   assign mapped     = dec_ff ? inv_q_ff : fwd_q_ff;

   always_comb begin
      folded = req_char_in;
      if (req_char_in inside {[CHAR_A_UP:CHAR_Z_UP]}) begin
         folded = req_char_in + CASE_OFFSET;
      end
      is_letter  = folded inside {[CHAR_A_LO:CHAR_Z_LO]};
      letter_idx = IDX_W'(folded - CHAR_A_LO);
   end

   always_comb begin
      state_in      = state_ff;
      mask_in       = mask_ff;
      fill_count_in = fill_count_ff;
      ready_in      = ready_ff;
      walk_in       = walk_ff;
      dec_in        = dec_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_char_in   = rsp_char_ff;
      rsp_status_in = rsp_status_ff;
      wr            = '0;
      rd_en         = 1'b0;
      rd_addr       = letter_idx;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               rsp_valid_in  = 1'b1;
               rsp_char_in   = 8'd0;
               rsp_status_in = ST_OK;
               case (req_operation)
                  OP_CLEAR: begin
                     mask_in       = '0;
                     fill_count_in = '0;
                     ready_in      = 1'b0;
                  end
                  OP_KEY: begin
                     if (ready_ff) begin
                        rsp_status_in = ST_REJECTED;
                     end else if (is_letter) begin
                        if (!mask_ff[letter_idx]) begin
                           wr.en         = 1'b1;
                           wr.fwd_addr   = fill_idx;
                           wr.fwd_data   = letter_idx;
                           wr.inv_addr   = letter_idx;
                           wr.inv_data   = fill_idx;
                           mask_in       = mask_ff | (ALPHA_SIZE'(1) << letter_idx);
                           fill_count_in = fill_count_ff + FILL_W'(1);
                        end
                     end else if (folded != CHAR_SPACE) begin
                        rsp_status_in = ST_REJECTED;
                     end
                  end
                  OP_FINISH: begin
                     if (!ready_ff) begin
                        rsp_valid_in = 1'b0;
                        walk_in      = '0;
                        state_in     = S_FILL;
                     end
                  end
                  OP_ENCRYPT, OP_DECRYPT: begin
                     rsp_char_in = req_char_in;
                     if (!ready_ff) begin
                        rsp_status_in = ST_NOT_READY;
                     end else if (is_letter) begin
                        rsp_valid_in = 1'b0;
                        rd_en        = 1'b1;
                        dec_in       = (req_operation == OP_DECRYPT);
                        state_in     = S_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_char_in   = CHAR_A_LO + 8'(mapped);
               rsp_status_in = ST_OK;
               state_in      = S_IDLE;
            end
         end
         S_FILL: begin
            if (!mask_ff[walk_ff]) begin
               wr.en         = 1'b1;
               wr.fwd_addr   = fill_idx;
               wr.fwd_data   = walk_ff;
               wr.inv_addr   = walk_ff;
               wr.inv_data   = fill_idx;
               mask_in       = mask_ff | (ALPHA_SIZE'(1) << walk_ff);
               fill_count_in = fill_count_ff + FILL_W'(1);
            end
            walk_in = walk_ff + IDX_W'(1);
            if (walk_ff == IDX_W'(ALPHA_SIZE - 1)) begin
               ready_in = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_char_in   = 8'd0;
               rsp_status_in = ST_OK;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mask_ff       <= '0;
         fill_count_ff <= '0;
         ready_ff      <= 1'b0;
         walk_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mask_ff       <= mask_in;
         fill_count_ff <= fill_count_in;
         ready_ff      <= ready_in;
         walk_ff       <= walk_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dec_ff        <= dec_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_status   = rsp_status_ff;

`ifndef NO_ASSERTIONS
   a_fill_matches_mask: assert property (@(posedge clock) disable iff (reset)
      $countones(mask_ff) == 32'(fill_count_ff))
      else $error("fill count differs from number of used letters");

   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> (fill_count_ff == FILL_W'(ALPHA_SIZE)) && (&mask_ff))
      else $error("table ready with unfilled entries");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("new beat taken while one is in flight");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff != 2'd3))
      else $error("undefined status code");

   a_read_when_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> ready_ff)
      else $error("table read before it is ready");
`endif

endmodule
`default_nettype wire
